// File: design/ups_pkg.sv
// ----------------------------------------------------------------------------
// ups_pkg
// Types, character codes and helper functions shared by the URL path
// sanitizer modules.
// ----------------------------------------------------------------------------
package ups_pkg;

   localparam int CNT_W       = 4;
   localparam int LIST_CHARS  = 4;
   localparam int FALLBACK_LEN = 10;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LF      = 8'h66;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UF      = 8'h46;

   typedef enum logic [1:0] {
      ESC_IDLE = 2'd0,
      ESC_HIGH = 2'd1,
      ESC_LOW  = 2'd2
   } esc_phase_type;

   typedef struct packed {
      logic [1:0]    raw_count;
      logic          raw_slash_seen;
      logic          first_raw_slash;
      logic          truncated;
      esc_phase_type escape_phase;
      logic [3:0]    high_nibble;
      logic          decoded_started;
      logic          decoded_slash_seen;
      logic [1:0]    held_dots;
      logic          segment_open;
      logic          segment_emitted;
      logic          rejected;
   } state_type;

   // one step's list of result transactions
   typedef struct packed {
      logic [CNT_W-1:0]            count;
      logic                        fallback;
      logic                        nochar;
      logic                        done;
      logic                        safe;
      logic [LIST_CHARS-1:0][7:0]  chars;
   } desc_type;

   // {valid, value} of a hex digit
   function automatic logic [4:0] nib_of(input logic [7:0] c);
      logic [7:0] diff;
      logic [4:0] res;
      diff = 8'd0;
      res  = 5'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         diff = c - CH_ZERO;
         res  = {1'b1, diff[3:0]};
      end else if (c >= CH_LA && c <= CH_LF) begin
         diff = c - CH_LA + 8'd10;
         res  = {1'b1, diff[3:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
         diff = c - CH_UA + 8'd10;
         res  = {1'b1, diff[3:0]};
      end
      return res;
   endfunction

   function automatic logic [7:0] fallback_char(input logic [CNT_W-1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h69;  // i
         4'd1:    ch = 8'h6E;  // n
         4'd2:    ch = 8'h64;  // d
         4'd3:    ch = 8'h65;  // e
         4'd4:    ch = 8'h78;  // x
         4'd5:    ch = CH_DOT;
         4'd6:    ch = 8'h68;  // h
         4'd7:    ch = 8'h74;  // t
         4'd8:    ch = 8'h6D;  // m
         4'd9:    ch = 8'h6C;  // l
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: design/ups_step.sv
// ----------------------------------------------------------------------------
// ups_step
// Per-character decision logic: escape decoding, segment tracking, reject
// rules and the list of result transactions one character causes.
// ----------------------------------------------------------------------------
module ups_step (
   input  ups_pkg::state_type state_cur,
   input  logic [7:0]         char_in,
   input  logic               last_char,
   output ups_pkg::state_type state_next,
   output logic               has_result,
   output ups_pkg::desc_type  desc
);
   import ups_pkg::*;

   always_comb begin
      state_type                  st;
      logic                       strip;
      logic [4:0]                 nib;
      logic                       d_valid;
      logic [7:0]                 d;
      logic                       emit_slash;
      logic [1:0]                 emit_dots;
      logic                       emit_d;
      logic [1:0]                 k;
      logic [CNT_W-1:0]           n_chars;
      logic [LIST_CHARS-1:0][7:0] chars;

      st         = state_cur;
      strip      = 1'b0;
      nib        = nib_of(char_in);
      d_valid    = 1'b0;
      d          = 8'd0;
      emit_slash = 1'b0;
      emit_dots  = 2'd0;
      emit_d     = 1'b0;
      k          = 2'd0;
      chars      = '0;

      if (!st.truncated && !st.rejected) begin
         priority if (char_in == CH_QUEST || char_in == CH_HASH) begin
            st.truncated = 1'b1;
         end else if (char_in == CH_BSLASH) begin
            st.rejected = 1'b1;
         end else if (char_in == CH_COLON && !st.raw_slash_seen) begin
            st.rejected = 1'b1;
         end else if (st.raw_count == 2'd1 && st.first_raw_slash && char_in == CH_SLASH) begin
            st.rejected = 1'b1;
         end else begin
            strip = (st.raw_count == 2'd0) && (char_in == CH_SLASH);
            if (st.raw_count == 2'd0) begin
               st.first_raw_slash = (char_in == CH_SLASH);
            end
            if (char_in == CH_SLASH) begin
               st.raw_slash_seen = 1'b1;
            end
            if (st.raw_count != 2'd2) begin
               st.raw_count = st.raw_count + 2'd1;
            end
            if (!strip) begin
               unique case (st.escape_phase)
                  ESC_IDLE: begin
                     if (char_in == CH_PERCENT) begin
                        st.escape_phase = ESC_HIGH;
                     end else begin
                        d_valid = 1'b1;
                        d       = char_in;
                     end
                  end
                  ESC_HIGH: begin
                     if (!nib[4]) begin
                        st.rejected = 1'b1;
                     end else begin
                        st.high_nibble  = nib[3:0];
                        st.escape_phase = ESC_LOW;
                     end
                  end
                  ESC_LOW: begin
                     if (!nib[4]) begin
                        st.rejected = 1'b1;
                     end else begin
                        st.escape_phase = ESC_IDLE;
                        d_valid         = 1'b1;
                        d               = {st.high_nibble, nib[3:0]};
                     end
                  end
                  default: st.escape_phase = ESC_IDLE;
               endcase
            end
         end

         if (d_valid) begin
            if (!st.decoded_started && d == CH_SLASH) begin
               st.rejected = 1'b1;
            end else begin
               st.decoded_started = 1'b1;
               priority if (d == CH_BSLASH) begin
                  st.rejected = 1'b1;
               end else if (d == CH_COLON && !st.decoded_slash_seen) begin
                  st.rejected = 1'b1;
               end else if (d == CH_SLASH) begin
                  st.decoded_slash_seen = 1'b1;
                  if (st.segment_open && st.held_dots != 2'd0) begin
                     st.rejected = 1'b1;
                  end else begin
                     st.segment_open = 1'b0;
                     st.held_dots    = 2'd0;
                  end
               end else if (!st.segment_open) begin
                  st.segment_open = 1'b1;
                  if (d == CH_DOT) begin
                     st.held_dots = 2'd1;
                  end else begin
                     emit_slash         = st.segment_emitted;
                     emit_d             = 1'b1;
                     st.segment_emitted = 1'b1;
                  end
               end else if (st.held_dots != 2'd0) begin
                  if (d == CH_DOT && st.held_dots == 2'd1) begin
                     st.held_dots = 2'd2;
                  end else begin
                     emit_slash         = st.segment_emitted;
                     emit_dots          = st.held_dots;
                     emit_d             = 1'b1;
                     st.held_dots       = 2'd0;
                     st.segment_emitted = 1'b1;
                  end
               end else begin
                  emit_d = 1'b1;
               end
            end
         end
      end

      // assemble the character list
      if (emit_slash) begin
         chars[k] = CH_SLASH;
         k        = k + 2'd1;
      end
      if (emit_dots != 2'd0) begin
         chars[k] = CH_DOT;
         k        = k + 2'd1;
      end
      if (emit_dots == 2'd2) begin
         chars[k] = CH_DOT;
         k        = k + 2'd1;
      end
      chars[k] = d;

      n_chars = (emit_d && !st.rejected) ?
                (CNT_W'(emit_slash) + CNT_W'(emit_dots) + CNT_W'(1)) : '0;

      desc       = '0;
      desc.chars = chars;
      desc.count = n_chars;
      has_result = (n_chars != '0);

      if (last_char) begin
         if (!st.rejected &&
             (st.escape_phase != ESC_IDLE || (st.segment_open && st.held_dots != 2'd0))) begin
            st.rejected = 1'b1;
         end
         desc.done = 1'b1;
         priority if (st.rejected) begin
            desc.nochar = 1'b1;
            desc.count  = CNT_W'(1);
            desc.safe   = 1'b0;
         end else if (!st.segment_emitted) begin
            desc.fallback = 1'b1;
            desc.count    = CNT_W'(FALLBACK_LEN);
            desc.safe     = 1'b1;
         end else if (n_chars == '0) begin
            desc.nochar = 1'b1;
            desc.count  = CNT_W'(1);
            desc.safe   = 1'b1;
         end else begin
            desc.safe = 1'b1;
         end
         has_result = 1'b1;
         st         = '0;
      end

      state_next = st;
   end

endmodule

// File: design/url_path_sanitizer.sv
// ----------------------------------------------------------------------------
// url_path_sanitizer
// Streaming URL path cleaner. Characters enter with a last flag; the cleaned
// path leaves one character per transaction, and the transaction that closes
// a URL carries the verdict (path_done, path_safe). A rejected URL closes
// with a single characterless transaction, and the consumer drops what it
// already took for it. One character is taken per cycle as long as each
// character causes at most one result and the output does not stall; a
// character that flushes a list (held dots, a separator, or the
// ten-character index.html fallback) makes a later character with a result
// wait until that list has left, since results leave the single output
// register one per cycle when not stalled. A character passes through an
// input register, then the step logic into the output list register.
// ----------------------------------------------------------------------------
module url_path_sanitizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_run_last,
   output logic       rsp_path_done,
   output logic       rsp_path_safe
);
   import ups_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_char_ff;
   logic             in_last_ff;
   state_type        state_ff, state_in;
   logic             list_valid_ff, list_valid_in;
   desc_type         list_ff, list_in;
   logic [CNT_W-1:0] pos_ff, pos_in;

   state_type        step_state;
   logic             step_has;
   desc_type         step_desc;

   logic             req_fire, rsp_fire, list_end, list_free, step_go;

   ups_step u_step (
      .state_cur  (state_ff),
      .char_in    (in_char_ff),
      .last_char  (in_last_ff),
      .state_next (step_state),
      .has_result (step_has),
      .desc       (step_desc)
   );

   assign list_end  = (pos_ff == list_ff.count - CNT_W'(1));
   assign rsp_fire  = list_valid_ff && !rsp_stall;
   assign list_free = !list_valid_ff || (rsp_fire && list_end);
   assign step_go   = in_valid_ff && (list_free || !step_has);
   assign req_stall = in_valid_ff && !step_go;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      in_valid_in   = in_valid_ff;
      state_in      = state_ff;
      list_valid_in = list_valid_ff;
      list_in       = list_ff;
      pos_in        = pos_ff;
      if (step_go) begin
         in_valid_in = 1'b0;
         state_in    = step_state;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
      end
      if (rsp_fire) begin
         if (list_end) begin
            list_valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + CNT_W'(1);
         end
      end
      if (step_go && step_has) begin
         list_valid_in = 1'b1;
         list_in       = step_desc;
         pos_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         state_ff      <= '0;
         list_valid_ff <= 1'b0;
         pos_ff        <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         state_ff      <= state_in;
         list_valid_ff <= list_valid_in;
         pos_ff        <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_last_char;
      end
      list_ff <= list_in;
   end

   always_comb begin
      if (list_ff.nochar) begin
         rsp_out_char = 8'd0;
      end else if (list_ff.fallback) begin
         rsp_out_char = fallback_char(pos_ff);
      end else begin
         rsp_out_char = list_ff.chars[pos_ff[1:0]];
      end
   end

   assign rsp_valid      = list_valid_ff;
   assign rsp_char_valid = !list_ff.nochar;
   assign rsp_run_last   = list_end;
   assign rsp_path_done  = list_ff.done && list_end;
   assign rsp_path_safe  = list_ff.safe && list_ff.done && list_end;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      list_valid_ff |-> (pos_ff < list_ff.count))
      else $error("list position past end");

   a_safe_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_path_safe |-> rsp_path_done && rsp_run_last)
      else $error("verdict outside closing transaction");

   a_list_holds: assert property (@(posedge clock) disable iff (reset)
      list_valid_ff && rsp_stall |=> list_valid_ff && $stable(pos_ff))
      else $error("stalled list moved");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_go |=> in_valid_ff && $stable(in_char_ff))
      else $error("held character lost");

   a_reject_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_path_done && !rsp_path_safe |-> !rsp_char_valid)
      else $error("rejected closing carries a character");

endmodule

// File: bench/tb_url_path_sanitizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_url_path_sanitizer
// Self-checking bench for the streaming URL path cleaner. A short table of
// URLs hits the edge characters, most rejection rules, truncation and the
// index.html fallback. Random URLs follow, most of them well formed with
// random segments and escapes, the rest noise or deliberately broken. Every
// result transaction is compared field by field against a cycle-free model
// of the path rules, with random handshake idles until the last third.
// ----------------------------------------------------------------------------
module tb_url_path_sanitizer;
   import ups_pkg::*;

   localparam int RANDOM_ITEMS = 290;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int ROW_COUNT    = 30;

   typedef struct packed {
      logic [7:0] ch;
      logic       ch_valid;
      logic       run_end;
      logic       done;
      logic       safe;
   } path_beat_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          is_last;
      logic          typed;
      path_beat_type beat;
   } stim_row_type;

   localparam path_beat_type NO_BEAT      = '0;
   localparam path_beat_type REJECT_CLOSE = '{ch: 8'h00, ch_valid: 1'b0, run_end: 1'b1,
                                              done: 1'b1, safe: 1'b0};
   localparam logic [0:9][7:0] INDEX_PAGE = "index.html";

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in = 8'h00;
   logic       req_last_char = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_char_valid;
   logic       rsp_run_last;
   logic       rsp_path_done;
   logic       rsp_path_safe;

   int req_idle_pct = 18;
   int rsp_idle_pct = 56;
   int err_count    = 0;
   int worked_items = 0;
   int quiet_cycles = 0;

   path_beat_type expected_beats[$];
   path_beat_type step_beats[$];
   logic [7:0]    url_text[$];

   // path rule state
   logic [1:0]    seen_cnt;
   logic          saw_raw_slash, lead_slash, cut_off;
   esc_phase_type esc;
   logic [3:0]    hi_nib;
   logic          any_decoded, saw_dec_slash;
   logic [1:0]    dots_held;
   logic          in_seg, text_out, bad;

   stim_row_type directed_rows [ROW_COUNT] = '{
      '{8'h00,      1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{8'hFF,      1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{CH_BSLASH,  1'b1, 1'b1, REJECT_CLOSE},
      '{CH_COLON,   1'b1, 1'b1, REJECT_CLOSE},
      '{CH_PERCENT, 1'b1, 1'b1, REJECT_CLOSE},
      '{CH_SLASH,   1'b0, 1'b0, NO_BEAT},
      '{CH_SLASH,   1'b1, 1'b1, REJECT_CLOSE},
      '{CH_SLASH,   1'b1, 1'b0, NO_BEAT},
      '{CH_PERCENT, 1'b0, 1'b0, NO_BEAT},
      '{"2",        1'b0, 1'b0, NO_BEAT},
      '{"f",        1'b1, 1'b0, NO_BEAT},
      '{CH_PERCENT, 1'b0, 1'b0, NO_BEAT},
      '{"G",        1'b1, 1'b1, REJECT_CLOSE},
      '{CH_DOT,     1'b0, 1'b0, NO_BEAT},
      '{CH_DOT,     1'b1, 1'b1, REJECT_CLOSE},
      '{"a",        1'b0, 1'b0, NO_BEAT},
      '{CH_SLASH,   1'b0, 1'b0, NO_BEAT},
      '{CH_PERCENT, 1'b0, 1'b0, NO_BEAT},
      '{"5",        1'b0, 1'b0, NO_BEAT},
      '{"c",        1'b1, 1'b1, REJECT_CLOSE},
      '{CH_PERCENT, 1'b0, 1'b0, NO_BEAT},
      '{"3",        1'b0, 1'b0, NO_BEAT},
      '{"A",        1'b1, 1'b1, REJECT_CLOSE},
      '{"x",        1'b0, 1'b0, NO_BEAT},
      '{CH_SLASH,   1'b0, 1'b0, NO_BEAT},
      '{CH_SLASH,   1'b0, 1'b0, NO_BEAT},
      '{CH_DOT,     1'b0, 1'b0, NO_BEAT},
      '{"y",        1'b0, 1'b0, NO_BEAT},
      '{CH_HASH,    1'b0, 1'b0, NO_BEAT},
      '{"z",        1'b1, 1'b0, NO_BEAT}
   };

   url_path_sanitizer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .req_last_char  (req_last_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_path_done  (rsp_path_done),
      .rsp_path_safe  (rsp_path_safe)
   );

   always #1 clock = ~clock;

   function automatic void clear_path_state();
      seen_cnt = 2'd0; saw_raw_slash = 1'b0; lead_slash = 1'b0; cut_off = 1'b0;
      esc = ESC_IDLE; hi_nib = 4'd0; any_decoded = 1'b0; saw_dec_slash = 1'b0;
      dots_held = 2'd0; in_seg = 1'b0; text_out = 1'b0; bad = 1'b0;
   endfunction

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      return -1;
   endfunction

   function automatic void put_beat(input logic [7:0] c);
      step_beats.push_back('{ch: c, ch_valid: 1'b1, run_end: 1'b0, done: 1'b0, safe: 1'b0});
   endfunction

   function automatic void open_text();
      if (text_out) put_beat(CH_SLASH);
      text_out = 1'b1;
   endfunction

   function automatic void take_decoded(input logic [7:0] d);
      if (!any_decoded && d == CH_SLASH) begin
         bad = 1'b1;
         return;
      end
      any_decoded = 1'b1;
      if (d == CH_BSLASH || (d == CH_COLON && !saw_dec_slash)) begin
         bad = 1'b1;
         return;
      end
      if (d == CH_SLASH) begin
         saw_dec_slash = 1'b1;
         if (in_seg && dots_held != 2'd0) begin
            bad = 1'b1;
            return;
         end
         in_seg = 1'b0;
         dots_held = 2'd0;
         return;
      end
      if (!in_seg) begin
         in_seg = 1'b1;
         if (d == CH_DOT) begin
            dots_held = 2'd1;
            return;
         end
         open_text();
         put_beat(d);
      end else if (dots_held != 2'd0) begin
         if (d == CH_DOT && dots_held == 2'd1) begin
            dots_held = 2'd2;
            return;
         end
         open_text();
         while (dots_held != 2'd0) begin
            put_beat(CH_DOT);
            dots_held--;
         end
         put_beat(d);
      end else begin
         put_beat(d);
      end
   endfunction

   function automatic void take_raw(input logic [7:0] c);
      int   v;
      logic strip;
      if (c == CH_QUEST || c == CH_HASH) begin
         cut_off = 1'b1;
         return;
      end
      if (c == CH_BSLASH || (c == CH_COLON && !saw_raw_slash) ||
          (seen_cnt == 2'd1 && lead_slash && c == CH_SLASH)) begin
         bad = 1'b1;
         return;
      end
      strip = (seen_cnt == 2'd0 && c == CH_SLASH);
      if (seen_cnt == 2'd0) lead_slash = (c == CH_SLASH);
      if (c == CH_SLASH) saw_raw_slash = 1'b1;
      if (seen_cnt < 2'd2) seen_cnt++;
      if (strip) return;
      v = hex_digit(c);
      case (esc)
         ESC_IDLE: begin
            if (c == CH_PERCENT) esc = ESC_HIGH;
            else take_decoded(c);
         end
         ESC_HIGH: begin
            if (v < 0) bad = 1'b1;
            else begin
               hi_nib = v[3:0];
               esc = ESC_LOW;
            end
         end
         default: begin
            if (v < 0) bad = 1'b1;
            else begin
               esc = ESC_IDLE;
               take_decoded({hi_nib, v[3:0]});
            end
         end
      endcase
   endfunction

   // fills step_beats with the transactions one character causes
   function automatic void sanitize_step(input logic [7:0] c, input logic is_last);
      path_beat_type tail;
      step_beats.delete();
      if (!cut_off && !bad) take_raw(c);
      if (bad) step_beats.delete();
      if (is_last) begin
         if (!bad && (esc != ESC_IDLE || (in_seg && dots_held != 2'd0))) bad = 1'b1;
         if (bad) begin
            step_beats.delete();
            step_beats.push_back(REJECT_CLOSE);
         end else begin
            if (!text_out)
               for (int i = 0; i < 10; i++) put_beat(INDEX_PAGE[i]);
            if (step_beats.size() == 0) step_beats.push_back(NO_BEAT);
            tail = step_beats.pop_back();
            tail.done = 1'b1;
            tail.safe = 1'b1;
            step_beats.push_back(tail);
         end
         clear_path_state();
      end
      if (step_beats.size() != 0) begin
         tail = step_beats.pop_back();
         tail.run_end = 1'b1;
         step_beats.push_back(tail);
      end
   endfunction

   function automatic logic [7:0] to_hex_char(input logic [3:0] v);
      if (v < 4'd10) return CH_ZERO + v;
      return ($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 8'd10;
   endfunction

   function automatic void add_path_char();
      int         pick;
      logic [7:0] b;
      pick = $urandom_range(0, 19);
      b = 8'($urandom_range(0, 255));
      if (pick < 8) url_text.push_back(8'(8'h61 + $urandom_range(0, 25)));
      else if (pick < 10) url_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      else if (pick < 13) begin
         url_text.push_back(CH_PERCENT);
         url_text.push_back(to_hex_char(b[7:4]));
         url_text.push_back(to_hex_char(b[3:0]));
      end else if (pick < 16) url_text.push_back(CH_DOT);
      else if (pick == 16) url_text.push_back(CH_COLON);
      else url_text.push_back(b);
   endfunction

   function automatic void make_url();
      int         kind;
      logic [7:0] b;
      logic [7:0] odd_chars [10];
      odd_chars = '{CH_SLASH, CH_DOT, CH_PERCENT, CH_COLON, CH_QUEST, CH_HASH,
                    CH_BSLASH, "a", "4", "E"};
      url_text.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         if ($urandom_range(0, 1)) url_text.push_back(CH_SLASH);
         for (int s = $urandom_range(1, 3); s > 0; s--) begin
            for (int k = $urandom_range(1, 3); k > 0; k--) add_path_char();
            if (s > 1) begin
               url_text.push_back(CH_SLASH);
               if ($urandom_range(0, 7) == 0) url_text.push_back(CH_SLASH);
            end
         end
         if ($urandom_range(0, 5) == 0) url_text.push_back(CH_SLASH);
         if ($urandom_range(0, 5) == 0) begin
            b = 8'($urandom_range(0, 255));
            url_text.push_back($urandom_range(0, 1) ? CH_QUEST : CH_HASH);
            url_text.push_back(b);
         end
      end else if (kind == 7) begin
         for (int k = $urandom_range(1, 8); k > 0; k--) begin
            b = 8'($urandom_range(0, 255));
            url_text.push_back(b);
         end
      end else if (kind == 8) begin
         for (int k = $urandom_range(1, 4); k > 0; k--) add_path_char();
         case ($urandom_range(0, 3))
            0: url_text.push_back(CH_BSLASH);
            1: begin
               url_text.push_back(CH_PERCENT);
               url_text.push_back("z");
            end
            2: begin
               url_text.push_back(CH_PERCENT);
               url_text.push_back(to_hex_char(4'($urandom_range(0, 15))));
            end
            default: url_text.push_back(CH_COLON);
         endcase
         for (int k = $urandom_range(0, 3); k > 0; k--) add_path_char();
      end else begin
         for (int k = $urandom_range(1, 8); k > 0; k--)
            url_text.push_back(odd_chars[$urandom_range(0, 9)]);
      end
   endfunction

   // starts and ends at a falling edge
   task automatic send_char(input logic [7:0] c, input logic is_last, input logic typed,
                            input path_beat_type beat);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_in   <= c;
      req_last_char <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      worked_items++;
      sanitize_step(c, is_last);
      if (typed) expected_beats.push_back(beat);
      else foreach (step_beats[k]) expected_beats.push_back(step_beats[k]);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         err_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   always @(posedge clock) begin : rsp_monitor
      path_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected transaction: out_char %0h", rsp_out_char);
            err_count++;
         end else begin
            want = expected_beats.pop_front();
            check_field("out_char", want.ch, rsp_out_char);
            check_field("char_valid", 8'(want.ch_valid), 8'(rsp_char_valid));
            check_field("run_last", 8'(want.run_end), 8'(rsp_run_last));
            check_field("path_done", 8'(want.done), 8'(rsp_path_done));
            check_field("path_safe", 8'(want.safe), 8'(rsp_path_safe));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      clear_path_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROW_COUNT; r++)
         send_char(directed_rows[r].ch, directed_rows[r].is_last, directed_rows[r].typed,
                   directed_rows[r].beat);

      worked_items = 0;
      while (worked_items < RANDOM_ITEMS) begin
         if (worked_items < RANDOM_ITEMS / 3) begin
            req_idle_pct = 18;
            rsp_idle_pct = 56;
         end else if (worked_items < 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 56;
            rsp_idle_pct = 18;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         make_url();
         foreach (url_text[i])
            send_char(url_text[i], i == url_text.size() - 1, 1'b0, NO_BEAT);
      end
      req_valid <= 1'b0;

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
design/ups_pkg.sv
design/ups_step.sv
design/url_path_sanitizer.sv
bench/tb_url_path_sanitizer.sv
